// ===== hdl/debounced_guarded_quadrature_decoder_defines.svh =====
// Assertion macros for the debounced guarded quadrature decoder.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef DEBOUNCED_GUARDED_QUADRATURE_DECODER_DEFINES_SVH
`define DEBOUNCED_GUARDED_QUADRATURE_DECODER_DEFINES_SVH

`ifndef SYNTH
// Checked only out of reset.
`define DGQD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dgqd assertion failed");
// Checked on every edge, reset included.
`define DGQD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dgqd assertion failed");
`else
`define DGQD_ASSERT(lbl, clk, rstn, prop)
`define DGQD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/dgqd_pkg.sv =====
// Shared types and constants for the debounced guarded quadrature decoder.
// No dependencies.
package dgqd_pkg;

    localparam int NUM_PINS = 3;
    localparam int PIN_A    = 0;
    localparam int PIN_B    = 1;
    localparam int PIN_C    = 2;

    // Event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_UP    = 2'd2;
    localparam logic [1:0] EV_DOWN  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_FILTER_STEP  = 2'd1;
    localparam logic [1:0] REG_PRESS_THR    = 2'd2;
    localparam logic [1:0] REG_RELEASE_THR  = 2'd3;

    // Reset values
    localparam logic       RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [5:0] RST_FILTER_STEP  = 6'h3F;
    localparam logic [7:0] RST_PRESS_THR    = 8'hF0;
    localparam logic [7:0] RST_RELEASE_THR  = 8'h0F;

    typedef struct packed {
        logic       active_level;
        logic [5:0] filter_step;
        logic [7:0] press_thr;
        logic [7:0] release_thr;
    } cfg_t;

endpackage

// ===== hdl/dgqd_filter.sv =====
// One pin lane: 8-bit low-pass filter followed by a hysteresis flag.
// Depends on dgqd_pkg for the configuration struct.
module dgqd_filter (
    input  logic            aclk,
    input  logic            aresetn,
    input  dgqd_pkg::cfg_t  cfg,
    input  logic            upd_en,
    input  logic            pin_raw,
    output logic            flag_cur,
    output logic            flag_next
);
    import dgqd_pkg::*;

    logic [7:0] y_reg;
    logic [7:0] y_next;
    logic       flag_reg;
    logic [7:0] y_decay;
    logic [7:0] add_val;
    logic       flag_set;

    always_comb begin
        y_decay  = y_reg - {2'b00, y_reg[7:2]};
        add_val  = (pin_raw == cfg.active_level) ? {2'b00, cfg.filter_step} : 8'd0;
        y_next   = y_decay + add_val;
        // Set test first, then clear test on the same new value
        flag_set  = flag_reg | (y_next > cfg.press_thr);
        flag_next = flag_set & ~(y_next < cfg.release_thr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg    <= 8'd0;
            flag_reg <= 1'b0;
        end else if (upd_en) begin
            y_reg    <= y_next;
            flag_reg <= flag_next;
        end
    end

    assign flag_cur = flag_reg;

endmodule

// ===== hdl/dgqd_decode.sv =====
// Event decode from the debounced flags: guard on C, direction from A against B.
// Depends on dgqd_pkg for pin positions and event codes.
module dgqd_decode (
    input  logic                           old_a,
    input  logic [dgqd_pkg::NUM_PINS-1:0]  flags_new,
    output logic [1:0]                     event_code
);
    import dgqd_pkg::*;

    always_comb begin
        event_code = EV_NONE;
        if (flags_new[PIN_C]) begin
            event_code = EV_CLICK;
            if (old_a != flags_new[PIN_A]) begin
                event_code = (flags_new[PIN_A] == flags_new[PIN_B]) ? EV_DOWN : EV_UP;
            end
        end
    end

endmodule

// ===== hdl/debounced_guarded_quadrature_decoder.sv =====
// Top level of the debounced guarded quadrature decoder: input register, three
// filter lanes, event decode and result register. Uses dgqd_pkg, dgqd_filter,
// dgqd_decode and the assertion macros header.
//
// One request on the input stream is one sample tick of pins A, B and C; it yields
// exactly one result (event code and debounced flags). A request is held in the
// input register, then the three filter lanes and the decode update the state and
// load the result register at the same edge, so requests are taken at one per
// cycle while the output is not stalled. A stalled result holds the pipeline; the
// input register still takes one more request. Configuration writes take effect
// on the next edge and are meant for an idle block. After reset all filters are
// zero, all flags at rest, and the registers hold active level 0, step 63, press
// 240, release 15.
`include "debounced_guarded_quadrature_decoder_defines.svh"

module debounced_guarded_quadrature_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] pin_a, [1] pin_b, [2] pin_c, [7:3] zero
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] event_res, [4:2] flags_now, [7:5] zero
    // Configuration
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);
    import dgqd_pkg::*;

    cfg_t                cfg_reg;
    logic                in_valid_reg;
    logic [NUM_PINS-1:0] pins_reg;
    logic                out_valid_reg;
    logic [1:0]          event_reg;
    logic [NUM_PINS-1:0] flags_reg;

    logic                advance;
    logic [NUM_PINS-1:0] flag_cur;
    logic [NUM_PINS-1:0] flag_next;
    logic [1:0]          event_next;

    // Move the held request into the result register when the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level <= RST_ACTIVE_LEVEL;
            cfg_reg.filter_step  <= RST_FILTER_STEP;
            cfg_reg.press_thr    <= RST_PRESS_THR;
            cfg_reg.release_thr  <= RST_RELEASE_THR;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ACTIVE_LEVEL: cfg_reg.active_level <= cfg_wdata[0];
                REG_FILTER_STEP:  cfg_reg.filter_step  <= cfg_wdata[5:0];
                REG_PRESS_THR:    cfg_reg.press_thr    <= cfg_wdata;
                REG_RELEASE_THR:  cfg_reg.release_thr  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= s_tdata[NUM_PINS-1:0];
        end
    end

    for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
        dgqd_filter u_filter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg_reg),
            .upd_en    (advance),
            .pin_raw   (pins_reg[i]),
            .flag_cur  (flag_cur[i]),
            .flag_next (flag_next[i])
        );
    end

    dgqd_decode u_decode (
        .old_a      (flag_cur[PIN_A]),
        .flags_new  (flag_next),
        .event_code (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            event_reg <= event_next;
            flags_reg <= flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, flags_reg, event_reg};

    `DGQD_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `DGQD_ASSERT(a_advance_fills_out, aclk, aresetn, advance |=> m_tvalid)
    `DGQD_ASSERT(a_held_request_kept, aclk, aresetn, (in_valid_reg && !advance) |=> in_valid_reg)
    `DGQD_ASSERT(a_event_needs_guard, aclk, aresetn, (m_tvalid && event_reg != EV_NONE) |-> flags_reg[PIN_C])
    `DGQD_ASSERT(a_state_frozen_idle, aclk, aresetn, !advance |=> $stable(flag_cur))

endmodule

// ===== dv/debounced_guarded_quadrature_decoder_tb.sv =====
// Self-checking testbench for the debounced guarded quadrature decoder: directed
// guard/edge cases, then randomized encoder motion under random stalls on both sides.
// Depends on dgqd_pkg and the debounced_guarded_quadrature_decoder RTL.
module debounced_guarded_quadrature_decoder_tb;
    import dgqd_pkg::*;

    typedef struct packed {
        logic [1:0] ev;
        logic [2:0] flags;
    } tick_result_t;

    bit          aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [0] pin_a, [1] pin_b, [2] pin_c, [7:3] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;     // [1:0] event_res, [4:2] flags_now, [7:5] zero
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    // Shadow of the decoder: register copy, low-pass values and hysteresis flags
    cfg_t         cur_cfg;
    logic [7:0]   lp_value [NUM_PINS];
    logic         db_flag  [NUM_PINS];
    tick_result_t pending_results [$];

    int fail_count = 0;
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_cycles_req = 0;
    int hold_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    debounced_guarded_quadrature_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic void clear_decoder_state();
        int i;
        cur_cfg = {RST_ACTIVE_LEVEL, RST_FILTER_STEP, RST_PRESS_THR, RST_RELEASE_THR};
        for (i = 0; i < NUM_PINS; i++) begin
            lp_value[i] = 8'd0;
            db_flag[i]  = 1'b0;
        end
    endfunction

    // Advance the shadow by one sample tick and queue the event it must produce
    function automatic void decode_tick(input logic [2:0] pins);
        int           i;
        logic         a_before;
        logic [8:0]   y;
        tick_result_t r;
        a_before = db_flag[PIN_A];
        for (i = 0; i < NUM_PINS; i++) begin
            y = {1'b0, lp_value[i]} - {3'b000, lp_value[i][7:2]} +
                ((pins[i] == cur_cfg.active_level) ? {3'b000, cur_cfg.filter_step} : 9'd0);
            lp_value[i] = y[7:0];
            // set test first, then clear test: inverted thresholds may do both
            if (y[7:0] > cur_cfg.press_thr && !db_flag[i])
                db_flag[i] = 1'b1;
            if (y[7:0] < cur_cfg.release_thr && db_flag[i])
                db_flag[i] = 1'b0;
        end
        r.ev = EV_NONE;
        if (db_flag[PIN_C]) begin
            r.ev = EV_CLICK;
            if (db_flag[PIN_A] != a_before)
                r.ev = (db_flag[PIN_A] == db_flag[PIN_B]) ? EV_DOWN : EV_UP;
        end
        r.flags = {db_flag[PIN_C], db_flag[PIN_B], db_flag[PIN_A]};
        pending_results.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the handshake
    task automatic send_sample(input logic [2:0] pins);
        while (tx_gaps && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, pins};
        do
            @(posedge aclk);
        while (!s_tready);
        decode_tick(pins);
        @(negedge aclk);
    endtask

    task automatic settle_pipeline();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
            pending_results.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    // Write all four registers on an idle block; unused upper data bits get noise
    task automatic load_config(input cfg_t c);
        settle_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_ACTIVE_LEVEL;
        cfg_wdata <= {7'($urandom), c.active_level};
        @(negedge aclk);
        cfg_addr  <= REG_FILTER_STEP;
        cfg_wdata <= {2'($urandom), c.filter_step};
        @(negedge aclk);
        cfg_addr  <= REG_PRESS_THR;
        cfg_wdata <= c.press_thr;
        @(negedge aclk);
        cfg_addr  <= REG_RELEASE_THR;
        cfg_wdata <= c.release_thr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        @(negedge aclk);
    endtask

    task automatic random_config(input logic level);
        cfg_t       c;
        int         ceiling;
        logic [7:0] swap;
        c.active_level = level;
        c.filter_step  = 6'($urandom_range(63, 12));
        // steady state of a held pin is four steps, approached from below
        ceiling        = 4 * c.filter_step - 8;
        c.press_thr    = 8'($urandom_range(ceiling, ceiling / 3));
        c.release_thr  = 8'($urandom_range(c.press_thr, 0));
        if ($urandom_range(4) == 0) begin
            swap          = c.press_thr;
            c.press_thr   = c.release_thr;
            c.release_thr = swap;
        end
        load_config(c);
    endtask

    // Mostly quadrature steps held for a few ticks with a slow guard, some glitches
    // and some raw noise
    task automatic drive_encoder_motion(input int count);
        int         sent;
        int         hold_len;
        logic [1:0] phase;
        logic [1:0] ab;
        logic       guard;
        logic [2:0] pins;
        sent  = 0;
        phase = 2'($urandom);
        guard = 1'($urandom);
        while (sent < count) begin
            if ($urandom_range(99) < 20) begin
                send_sample(3'($urandom));
                sent++;
            end else begin
                phase = $urandom_range(1) ? phase + 2'd1 : phase - 2'd1;
                ab    = phase ^ (phase >> 1);
                if ($urandom_range(99) < 15)
                    guard = ~guard;
                hold_len = $urandom_range(8, 1);
                repeat (hold_len) begin
                    pins = {guard, ab[1], ab[0]};
                    if ($urandom_range(99) < 5)
                        pins[$urandom_range(2)] ^= 1'b1;
                    send_sample(pins);
                    sent++;
                end
            end
        end
    endtask

    // Click, down, up and guard-at-rest with thresholds that switch in a few ticks
    task automatic test_guard_and_direction();
        load_config({1'b0, 6'd63, 8'h80, 8'h40});
        repeat (3) send_sample(3'b000);
        repeat (3) send_sample(3'b001);
        repeat (3) send_sample(3'b100);
        repeat (5) send_sample(3'b101);
    endtask

    task automatic test_extreme_settings();
        // active high, largest step, press never reachable, release never reachable
        load_config({1'b1, 6'd63, 8'hFF, 8'h00});
        send_sample(3'b111);
        send_sample(3'b000);
        send_sample(3'b111);
        // no step at all, fully inverted thresholds
        load_config({1'b0, 6'd0, 8'h00, 8'hFF});
        send_sample(3'b000);
        send_sample(3'b111);
        // inverted band: a flag only survives the tick above the release level
        load_config({1'b0, 6'd63, 8'h40, 8'hC0});
        repeat (4) send_sample(3'b000);
    endtask

    task automatic test_random_traffic();
        int p;
        load_config({RST_ACTIVE_LEVEL, RST_FILTER_STEP, RST_PRESS_THR, RST_RELEASE_THR});
        drive_encoder_motion(150);
        for (p = 0; p < 6; p++) begin
            random_config(1'($urandom));
            drive_encoder_motion(150);
        end
    endtask

    task automatic test_no_idle_stretch();
        random_config(1'b0);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        drive_encoder_motion(150);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Hold the result side long enough that the input side must stall
    task automatic test_output_backpressure();
        random_config(1'b1);
        tx_gaps = 1'b0;
        hold_cycles_req = 200;
        drive_encoder_motion(40);
        tx_gaps = 1'b1;
    endtask

    always @(negedge aclk) begin
        if (hold_cycles_req > 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_gaps) begin
            m_tready <= ($urandom_range(99) >= 29);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: event_res %0d flags_now %0d",
                       m_tdata[1:0], m_tdata[4:2]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.ev) begin
                    $error("event_res mismatch: expected %0d, got %0d", want.ev, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[4:2] !== want.flags) begin
                    $error("flags_now mismatch: expected %0d, got %0d",
                           want.flags, m_tdata[4:2]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_ACTIVE_LEVEL;
        cfg_wdata = 8'd0;
        clear_decoder_state();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_guard_and_direction();
        test_extreme_settings();
        test_random_traffic();
        test_no_idle_stretch();
        test_output_backpressure();
        settle_pipeline();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS debounced_guarded_quadrature_decoder");
        else
            $display("FAIL debounced_guarded_quadrature_decoder");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL debounced_guarded_quadrature_decoder");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dgqd_pkg.sv
hdl/dgqd_filter.sv
hdl/dgqd_decode.sv
hdl/debounced_guarded_quadrature_decoder.sv
dv/debounced_guarded_quadrature_decoder_tb.sv
